@@ hdl/assert_macros.svh @@
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/tbw_pkg.sv @@
// Package: shared types and constants of the barycentric weight block.
package tbw_pkg;
    localparam int W_WIDTH = 21;
    localparam int FRAC_BITS = 16;
    localparam int ONE_Q16 = 65536;
    localparam int W_MAX = 1048575;
    localparam int W_MIN = -1048576;
    localparam int DEGEN_LIMIT = 256;

    localparam logic [2:0] REG_V0X = 3'd0;
    localparam logic [2:0] REG_V0Y = 3'd1;
    localparam logic [2:0] REG_V1X = 3'd2;
    localparam logic [2:0] REG_V1Y = 3'd3;
    localparam logic [2:0] REG_V2X = 3'd4;
    localparam logic [2:0] REG_V2Y = 3'd5;

    // Result word as it travels through the back end.
    typedef struct packed {
        logic signed [W_WIDTH-1:0] weight0;
        logic signed [W_WIDTH-1:0] weight1;
        logic signed [W_WIDTH-1:0] weight2;
        logic                      degenerate;
    } result_t;
endpackage

@@ hdl/tbw_front.sv @@
// Front end: edge setup and cross product, three registered stages.
module tbw_front #(
    parameter int CW = 16,
    parameter int NW = 2 * CW + 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] px,
    input  logic signed [CW-1:0] py,
    input  logic signed [CW-1:0] x0,
    input  logic signed [CW-1:0] y0,
    input  logic signed [CW-1:0] x1,
    input  logic signed [CW-1:0] y1,
    input  logic signed [CW-1:0] x2,
    input  logic signed [CW-1:0] y2,
    input  logic                 advance,
    output logic                 out_valid,
    output logic signed [NW-1:0] cx,
    output logic signed [NW-1:0] cy,
    output logic signed [NW-1:0] cz
);
    import tbw_pkg::*;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    logic [2:0] vld_reg;
    logic signed [DW-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [NW-1:0] cx_reg, cy_reg, cz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ax_reg <= DW'(x2) - DW'(x0);
            ay_reg <= DW'(x1) - DW'(x0);
            az_reg <= DW'(x0) - DW'(px);
            bx_reg <= DW'(y2) - DW'(y0);
            by_reg <= DW'(y1) - DW'(y0);
            bz_reg <= DW'(y0) - DW'(py);
            p0_reg <= ay_reg * bz_reg;
            p1_reg <= az_reg * by_reg;
            p2_reg <= az_reg * bx_reg;
            p3_reg <= ax_reg * bz_reg;
            p4_reg <= ax_reg * by_reg;
            p5_reg <= ay_reg * bx_reg;
            cx_reg <= NW'(p0_reg) - NW'(p1_reg);
            cy_reg <= NW'(p2_reg) - NW'(p3_reg);
            cz_reg <= NW'(p4_reg) - NW'(p5_reg);
        end
    end

    assign out_valid = vld_reg[2];
    assign cx = cx_reg;
    assign cy = cy_reg;
    assign cz = cz_reg;
endmodule

@@ hdl/tbw_queue.sv @@
// Short queue between front and back end.
module tbw_queue #(
    parameter int DW = 8,
    parameter int DEPTH = 4,
    parameter int AW = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    input  logic [DW-1:0] wr_data,
    output logic [AW:0]   count,
    input  logic          rd_ready,
    output logic          rd_valid,
    output logic [DW-1:0] rd_data
);
    logic [DW-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          rd;

    assign rd = rd_ready && (cnt_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_valid) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_valid) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_valid) mem_reg[wp_reg] <= wr_data;
    end

    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign count    = cnt_reg;
endmodule

@@ hdl/tbw_back.sv @@
// Back end: pipelined restoring dividers, weight forming and output register.
module tbw_back #(
    parameter int NW = 36
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [NW-1:0] cx,
    input  logic signed [NW-1:0] cy,
    input  logic signed [NW-1:0] cz,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tbw_pkg::result_t     out_data
);
    import tbw_pkg::*;
    // Quotient: 5 integer bits + 16 fraction bits; beyond that it clamps.
    localparam int QB = 5 + FRAC_BITS;
    localparam int MW = NW + 1;
    // Remainder holds |num| scaled by 2^16.
    localparam int RW = MW + FRAC_BITS;
    localparam int CMPW = MW + QB;

    typedef struct packed {
        logic [RW-1:0] r;
        logic [QB-1:0] q;
        logic          ovf;
        logic          neg;
    } lane_t;

    logic          vld_reg [QB+1];
    logic          deg_reg [QB+1];
    logic [MW-1:0] d_reg   [QB+1];
    lane_t         ln_reg  [QB+1][3];
    result_t       res_reg;
    logic          res_vld_reg;
    logic          adv;

    assign adv = !res_vld_reg || out_ready;
    assign in_ready = adv;

    function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
        mag = v[MW-1] ? MW'(-v) : v;
    endfunction

    logic signed [MW-1:0] nums [3];
    logic [MW-1:0] dmag;
    assign nums[0] = MW'(cx) + MW'(cy);
    assign nums[1] = MW'(cy);
    assign nums[2] = MW'(cx);
    assign dmag = mag(MW'(cz));

    // Stage 0: magnitudes and overflow test (|n| >= 32*|d|).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= QB; s++) vld_reg[s] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= QB; s++) vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        lane_t         nl;
        logic [MW-1:0] nm;
        if (adv) begin
            d_reg[0]   <= dmag;
            deg_reg[0] <= (dmag < MW'(DEGEN_LIMIT));
            for (int k = 0; k < 3; k++) begin
                nm     = mag(nums[k]);
                nl.r   = {nm, {FRAC_BITS{1'b0}}};
                nl.q   = '0;
                nl.neg = nums[k][MW-1] ^ cz[NW-1];
                nl.ovf = (MW+5)'(nm) >= ((MW+5)'(dmag) << 5);
                ln_reg[0][k] <= nl;
            end
            // One quotient bit per stage, MSB first.
            for (int s = 1; s <= QB; s++) begin
                d_reg[s]   <= d_reg[s-1];
                deg_reg[s] <= deg_reg[s-1];
                for (int k = 0; k < 3; k++) begin
                    nl = ln_reg[s-1][k];
                    if (CMPW'(nl.r) >= (CMPW'(d_reg[s-1]) << (QB - s))) begin
                        nl.r = nl.r - RW'(CMPW'(d_reg[s-1]) << (QB - s));
                        nl.q = nl.q | (QB'(1) << (QB - s));
                    end
                    ln_reg[s][k] <= nl;
                end
            end
        end
    end

    // Final: sign, clamp, weight0 = 1 - q, saturation, degenerate forces -1.0.
    logic signed [QB+3:0] sq [3];
    logic signed [QB+3:0] w  [3];
    result_t              res_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (ln_reg[QB][k].ovf) begin
                sq[k] = (QB+4)'(2097152);
            end else begin
                sq[k] = (QB+4)'(ln_reg[QB][k].q);
            end
            if (ln_reg[QB][k].neg) sq[k] = -sq[k];
        end
        w[0] = (QB+4)'(ONE_Q16) - sq[0];
        w[1] = sq[1];
        w[2] = sq[2];
        for (int k = 0; k < 3; k++) begin
            if (w[k] > (QB+4)'(W_MAX)) w[k] = (QB+4)'(W_MAX);
            if (w[k] < (QB+4)'(W_MIN)) w[k] = (QB+4)'(W_MIN);
        end
        res_next.weight0 = W_WIDTH'(w[0]);
        res_next.weight1 = W_WIDTH'(w[1]);
        res_next.weight2 = W_WIDTH'(w[2]);
        res_next.degenerate = deg_reg[QB];
        if (deg_reg[QB]) begin
            res_next.weight0 = W_WIDTH'(-ONE_Q16);
            res_next.weight1 = W_WIDTH'(-ONE_Q16);
            res_next.weight2 = W_WIDTH'(-ONE_Q16);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_vld_reg <= 1'b0;
        end else if (adv) begin
            res_vld_reg <= vld_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) res_reg <= res_next;
    end

    assign out_valid = res_vld_reg;
    assign out_data  = res_reg;
endmodule

@@ hdl/triangle_barycentric_weights.sv @@
// Top level: barycentric weights of a query point in a 2D triangle.
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes vertex
//    registers 0..5 (v0x, v0y, v1x, v1y, v2x, v2y); other indexes are ignored.
//    Write only while the block is idle. cfg_ready is always high.
//  - s_axis: one word per query point, tdata = {point_y, point_x}.
//  - m_axis: one word per point, tdata = {weight2, weight1, weight0},
//    tuser = degenerate.
// Throughput: one word per cycle while the receiver does not stall, set by
//  the fully pipelined front end (three stages of setup and cross product)
//  and the back end's restoring dividers, one quotient bit per stage.
// Stages: 3 registers in the front end, 1 through the queue, 23 in the back
//  end.
// The queue keeps room for every word in flight in the front end, so
//  s_axis_tready drops only when queue plus front end would overflow.
// Receiver stall: the back end pipeline and its output register hold; the
//  front end keeps draining into the queue, which has room reserved for it.
// Reset (aresetn low, synchronous): clears vertices to zero and empties
//  all pipeline valid bits and the queue.
module triangle_barycentric_weights #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [COORD_WIDTH-1:0]       cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // point_x [CW-1:0], point_y [2CW-1:CW], zero pad
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // weight0 [20:0], weight1 [41:21], weight2 [62:42], zero pad [63]
    output logic [63:0]                  m_axis_tdata,
    // degenerate
    output logic                         m_axis_tuser
);
    import tbw_pkg::*;
    `include "assert_macros.svh"

    localparam int CW = COORD_WIDTH;
    localparam int NW = 2 * CW + 4;
    localparam int QDEPTH = 8;
    localparam int QAW = 3;
    localparam int FRONT_STAGES = 3;

    logic signed [CW-1:0] v0x_reg, v0y_reg, v1x_reg, v1y_reg, v2x_reg, v2y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0x_reg <= '0; v0y_reg <= '0; v1x_reg <= '0;
            v1y_reg <= '0; v2x_reg <= '0; v2y_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_V0X: v0x_reg <= cfg_data;
                REG_V0Y: v0y_reg <= cfg_data;
                REG_V1X: v1x_reg <= cfg_data;
                REG_V1Y: v1y_reg <= cfg_data;
                REG_V2X: v2x_reg <= cfg_data;
                REG_V2Y: v2y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front end never stalls; admission is limited by free queue space.
    logic              f_vld;
    logic signed [NW-1:0] cx, cy, cz;
    logic [QAW:0]      q_count;
    logic [2:0]        inflight_reg;
    logic              accept;
    logic              q_rd_valid, q_rd_ready;
    logic [3*NW-1:0]   q_rd_data;
    result_t           res;

    assign s_axis_tready = (32'(q_count) + 32'(inflight_reg)) < QDEPTH;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_reg + 3'(accept) - 3'(f_vld);
        end
    end

    tbw_front #(.CW(CW), .NW(NW)) u_front (
        .aclk, .aresetn,
        .in_valid (accept),
        .px (s_axis_tdata[CW-1:0]), .py (s_axis_tdata[2*CW-1:CW]),
        .x0 (v0x_reg), .y0 (v0y_reg), .x1 (v1x_reg),
        .y1 (v1y_reg), .x2 (v2x_reg), .y2 (v2y_reg),
        .advance (1'b1),
        .out_valid (f_vld), .cx, .cy, .cz
    );

    tbw_queue #(.DW(3*NW), .DEPTH(QDEPTH), .AW(QAW)) u_queue (
        .aclk, .aresetn,
        .wr_valid (f_vld), .wr_data ({cz, cy, cx}),
        .count (q_count),
        .rd_ready (q_rd_ready), .rd_valid (q_rd_valid), .rd_data (q_rd_data)
    );

    tbw_back #(.NW(NW)) u_back (
        .aclk, .aresetn,
        .in_valid (q_rd_valid), .in_ready (q_rd_ready),
        .cx (q_rd_data[NW-1:0]), .cy (q_rd_data[2*NW-1:NW]),
        .cz (q_rd_data[3*NW-1:2*NW]),
        .out_valid (m_axis_tvalid), .out_ready (m_axis_tready),
        .out_data (res)
    );

    assign m_axis_tdata = {1'b0, res.weight2, res.weight1, res.weight0};
    assign m_axis_tuser = res.degenerate;

    `ASSERT_IMPL(a_no_overflow, aclk, aresetn, 1'b1,
        (32'(q_count) + 32'(inflight_reg)) <= QDEPTH, "queue overcommitted")
    `ASSERT_IMPL(a_inflight, aclk, aresetn, 1'b1,
        32'(inflight_reg) <= FRONT_STAGES, "front end count off")
    `ASSERT_IMPL(a_degen_val, aclk, aresetn, m_axis_tvalid && m_axis_tuser,
        res.weight0 == W_WIDTH'(-ONE_Q16), "degenerate weight wrong")
endmodule

@@ test/triangle_barycentric_weights_tb.sv @@
// Testbench for the barycentric weight block: self-checking, random and directed.
`timescale 1ns / 100ps

module triangle_barycentric_weights_tb;
    import tbw_pkg::*;

    localparam int CW = 16;
    localparam int LATENCY = 27;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // point_x [15:0], point_y [31:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // weight0 [20:0], weight1 [41:21], weight2 [62:42], pad
    logic        m_axis_tuser;        // degenerate

    triangle_barycentric_weights #(.COORD_WIDTH(CW)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Testbench copy of the vertex registers.
    logic signed [CW-1:0] vert [6];
    result_t weight_queue [$];
    int n_errors = 0;
    int n_points = 0;
    int n_results = 0;
    int n_degen = 0;
    int n_sat = 0;
    bit sink_stall_en = 1'b1;

    // Random gap: mostly zero or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Q.16 quotient truncated toward zero, clamped when the integer part is >= 32.
    function automatic longint div_q16(longint num, longint den);
        longint un, ud, m;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        if (un / ud >= 32) m = 64'sd2097152;
        else m = (un << FRAC_BITS) / ud;
        return ((num < 0) != (den < 0)) ? -m : m;
    endfunction

    function automatic logic signed [W_WIDTH-1:0] clamp_weight(longint w);
        if (w > W_MAX) begin
            n_sat++;
            return W_WIDTH'(W_MAX);
        end
        if (w < W_MIN) begin
            n_sat++;
            return W_WIDTH'(W_MIN);
        end
        return w[W_WIDTH-1:0];
    endfunction

    function automatic result_t predict_weights(logic signed [CW-1:0] px,
                                                logic signed [CW-1:0] py);
        longint ax, ay, az, bx, by, bz, cx, cy, cz;
        result_t r;
        ax = longint'(vert[4]) - vert[0];
        ay = longint'(vert[2]) - vert[0];
        az = longint'(vert[0]) - px;
        bx = longint'(vert[5]) - vert[1];
        by = longint'(vert[3]) - vert[1];
        bz = longint'(vert[1]) - py;
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        // Twice the area below one: every weight forced to -1.0.
        if (cz > -DEGEN_LIMIT && cz < DEGEN_LIMIT) begin
            r.weight0 = W_WIDTH'(-ONE_Q16);
            r.weight1 = W_WIDTH'(-ONE_Q16);
            r.weight2 = W_WIDTH'(-ONE_Q16);
            r.degenerate = 1'b1;
            n_degen++;
            return r;
        end
        r.weight0 = clamp_weight(ONE_Q16 - div_q16(cx + cy, cz));
        r.weight1 = clamp_weight(div_q16(cy, cz));
        r.weight2 = clamp_weight(div_q16(cx, cz));
        r.degenerate = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0d expected %0d", n_results, what, got, want);
        n_errors++;
    endtask

    // Register write; only called with no words in flight.
    task automatic write_vertex(logic [2:0] idx, logic [CW-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx <= REG_V2Y) vert[idx] = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (weight_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic idle_input();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic load_triangle(logic [CW-1:0] x0, y0, x1, y1, x2, y2);
        idle_input();
        wait_drained();
        write_vertex(REG_V0X, x0);
        write_vertex(REG_V0Y, y0);
        write_vertex(REG_V1X, x1);
        write_vertex(REG_V1Y, y1);
        write_vertex(REG_V2X, x2);
        write_vertex(REG_V2Y, y2);
    endtask

    // Send one query point, with an optional gap before it.
    task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py, bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (g - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        do @(posedge aclk); while (!s_axis_tready);
        weight_queue.push_back(predict_weights(px, py));
        n_points++;
    endtask

    // Result checker, sampled at the rising edge.
    always @(posedge aclk) begin
        result_t want;
        logic signed [W_WIDTH-1:0] g0, g1, g2;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            g0 = m_axis_tdata[20:0];
            g1 = m_axis_tdata[41:21];
            g2 = m_axis_tdata[62:42];
            if (weight_queue.size() == 0) begin
                $display("MISMATCH unexpected result word");
                n_errors++;
            end else begin
                want = weight_queue.pop_front();
                if (g0 !== want.weight0) report_mismatch("weight0", g0, want.weight0);
                if (g1 !== want.weight1) report_mismatch("weight1", g1, want.weight1);
                if (g2 !== want.weight2) report_mismatch("weight2", g2, want.weight2);
                if (m_axis_tuser !== want.degenerate)
                    report_mismatch("degenerate", m_axis_tuser, want.degenerate);
            end
            n_results++;
        end
    end

    // Sink backpressure, driven on the falling edge.
    always @(negedge aclk) begin
        int g;
        if (!sink_stall_en) begin
            m_axis_tready <= 1'b1;
        end else if (m_axis_tready) begin
            g = pick_gap();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(negedge aclk);
                m_axis_tready <= 1'b1;
            end
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic test_reset_vertices();
        // All vertices zero after reset: every point is degenerate.
        send_point(16'sh0000, 16'sh0000, 0);
        send_point(16'sh7FFF, 16'sh8000, 0);
        idle_input();
    endtask

    task automatic test_directed();
        // Unit right triangle (1.0 = 16 in Q12.4): interior, vertices, outside.
        load_triangle(16'd0, 16'd0, 16'd16, 16'd0, 16'd0, 16'd16);
        send_point(16'd0, 16'd0, 0);
        send_point(16'd16, 16'd0, 0);
        send_point(16'd0, 16'd16, 0);
        send_point(16'd5, 16'd5, 0);
        send_point(16'h7FFF, 16'h7FFF, 0);   // far outside: saturates
        send_point(16'h8000, 16'h8000, 0);
        send_point(16'h7FFF, 16'h8000, 0);
        send_point(16'hFFFF, 16'h0001, 0);
        idle_input();
        // Tiny triangle: |cz| just below and at the area limit.
        load_triangle(16'd0, 16'd0, 16'd15, 16'd0, 16'd0, 16'd17);   // cz = -255
        send_point(16'd3, 16'd3, 0);
        load_triangle(16'd0, 16'd0, 16'd16, 16'd0, 16'd0, 16'd16);   // cz = -256
        send_point(16'd3, 16'd3, 0);
        load_triangle(16'd0, 16'd0, 16'd0, 16'd16, 16'd16, 16'd0);   // cz = 256
        send_point(16'd3, 16'd3, 0);
        send_point(16'h8000, 16'h7FFF, 0);
        idle_input();
        // Extreme vertices: largest cross products.
        load_triangle(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_point(16'h0000, 16'h0000, 0);
        send_point(16'h8000, 16'h8000, 0);
        send_point(16'h7FFF, 16'h7FFF, 0);
        send_point(16'hAAAA, 16'h5555, 0);
        // Collinear vertices: degenerate.
        load_triangle(16'd0, 16'd0, 16'd100, 16'd100, 16'd200, 16'd200);
        send_point(16'd50, 16'd20, 0);
        send_point(16'h5555, 16'hAAAA, 0);
        idle_input();
    endtask

    task automatic test_random_triangles(int n_tri);
        int span, k, n;
        logic [CW-1:0] x0, y0, px, py;
        for (int t = 0; t < n_tri; t++) begin
            k = $urandom_range(0, 9);
            // Mostly moderate sizes so weights stay in range; some full-range.
            span = (k < 6) ? $urandom_range(64, 4096) : (k < 9) ? 32767 : 16;
            x0 = $urandom;
            y0 = $urandom;
            if (k == 9) begin
                load_triangle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                load_triangle(x0, y0,
                              x0 + $urandom_range(0, 2 * span) - span,
                              y0 + $urandom_range(0, 2 * span) - span,
                              x0 + $urandom_range(0, 2 * span) - span,
                              y0 + $urandom_range(0, 2 * span) - span);
            end
            sink_stall_en = ($urandom_range(0, 3) != 0);
            n = $urandom_range(30, 60);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) < 8) begin
                    px = vert[0] + $urandom_range(0, 2 * span) - span;
                    py = vert[1] + $urandom_range(0, 2 * span) - span;
                end else begin
                    px = $urandom;
                    py = $urandom;
                end
                send_point(px, py, t % 4 != 0);
            end
            idle_input();
            sink_stall_en = 1'b1;
        end
    endtask

    initial begin
        for (int i = 0; i < 6; i++) vert[i] = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_vertices();
        test_directed();
        test_random_triangles(25);
        wait_drained();
        $display("Covered %0d points, %0d degenerate, %0d saturated weights.",
                 n_points, n_degen, n_sat);
        if (n_errors == 0 && weight_queue.size() == 0) begin
            $display("triangle_barycentric_weights verification clean");
        end else begin
            if (weight_queue.size() != 0)
                $display("%0d results never arrived", weight_queue.size());
            $display("triangle_barycentric_weights verification failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout: %0d results still expected", weight_queue.size());
        $display("triangle_barycentric_weights verification failed");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hdl
hdl/tbw_pkg.sv
hdl/tbw_front.sv
hdl/tbw_queue.sv
hdl/tbw_back.sv
hdl/triangle_barycentric_weights.sv
test/triangle_barycentric_weights_tb.sv
